[rtl/lfu_cache_table_top_macros.svh]
// Assertion macros used by the checker file.
`ifndef LFU_CACHE_TABLE_TOP_MACROS_SVH
`define LFU_CACHE_TABLE_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define LFU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfu check failed");
// Implication checked in the cycle after the antecedent.
`define LFU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfu check failed");
`endif

[rtl/lfu_pkg.sv]
// Shared types and constants for the LFU cache table.
package lfu_pkg;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 32;
  localparam int STAMP_W = 48;
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // One stored entry, as kept in the entry memory.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [CNT_W-1:0]   count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // One result word.
  typedef struct packed {
    logic             evicted;
    logic [VAL_W-1:0] read_value;
    logic             hit;
  } result_t;
endpackage

[rtl/lfu_mem.sv]
// Entry memory: one write port, one registered read port.
module lfu_mem import lfu_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);
  entry_t mem [DEPTH];

  // Synchronous write and read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/lfu_cache_table_top.sv]
// Channel  | direction | word contents
// s_axis   | in        | tdata: opcode, lookup_key, write_value
// m_axis   | out       | tdata: hit, read_value, evicted
// apb      | in/out    | register 0: capacity at address 0
// Each item is handled by a scan that reads the entry memory one address a
// cycle for key match and victim choice, then by a write-back step. The read
// port of the single entry memory sets this pace.
// Reset is synchronous and clears valid bits, occupancy and access clock.
// A finished result sits in the output register; the next item is taken
// while it waits, but a new result is held until the old one leaves.
module lfu_cache_table_top import lfu_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] opcode, [32:1] lookup_key, [64:33] write_value, [71:65] zero
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] hit, [32:1] read_value, [33] evicted, [39:34] zero
  output logic [39:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int OW = (CW > 5) ? CW : 5;
  localparam logic [2:0] ST_IDLE = 3'd0, ST_SCAN = 3'd1, ST_LAST = 3'd2,
                         ST_WB = 3'd3, ST_OUT = 3'd4;

  // Configuration register.
  logic [4:0] capacity;
  assign pready = 1'b1;
  assign prdata = {27'd0, capacity};
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 5'd16;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      capacity <= pwdata[4:0];
    end
  end

  logic [2:0] state;
  logic [MAX_ENTRIES-1:0] valid;
  logic [OW-1:0] occupancy;
  logic [STAMP_W-1:0] access_clock;
  logic op;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] wval;
  logic [AW:0] idx;
  logic [AW-1:0] rd_idx;
  logic found, vfound, ffound;
  logic [AW-1:0] hit_idx, vic_idx, free_idx;
  entry_t hit_ent, vic_ent;
  entry_t rdata, wdata;
  logic [AW-1:0] raddr, waddr;
  logic we;
  result_t res;
  logic res_pend, out_valid;
  logic [39:0] out_data;
  logic [OW-1:0] cap_eff;

  assign cap_eff = (OW'(capacity) > OW'(MAX_ENTRIES)) ? OW'(MAX_ENTRIES) : OW'(capacity);

  lfu_mem #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata));

  assign raddr = idx[AW-1:0];
  assign s_axis_tready = (state == ST_IDLE) && !res_pend;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Victim compare on the word just read.
  logic rd_ok, better;
  assign rd_ok = valid[rd_idx];
  assign better = !vfound || rdata.count < vic_ent.count ||
                  (rdata.count == vic_ent.count && rdata.stamp < vic_ent.stamp);

  // Write-back decisions.
  logic is_hit, do_ins, do_ev;
  logic [AW-1:0] ins_idx;
  assign is_hit = found;
  assign do_ev  = !found && op == OP_PUT && cap_eff != '0 &&
                  occupancy >= cap_eff && vfound;
  assign ins_idx = ffound ? free_idx : vic_idx;
  assign do_ins = !found && op == OP_PUT && cap_eff != '0 && (ffound || do_ev);

  always_comb begin
    we = 1'b0;
    waddr = hit_idx;
    wdata = hit_ent;
    if (state == ST_WB) begin
      if (is_hit && (op == OP_GET || cap_eff != '0)) begin
        we = 1'b1;
        if (hit_ent.count != COUNT_MAX) wdata.count = hit_ent.count + 1'b1;
        wdata.stamp = access_clock;
        if (op == OP_PUT) wdata.value = wval;
      end else if (do_ins) begin
        we = 1'b1;
        // With eviction the victim's slot is written, else the lowest free slot.
        waddr = do_ev ? vic_idx : ins_idx;
        wdata.key = key;
        wdata.value = wval;
        wdata.count = CNT_W'(1);
        wdata.stamp = access_clock;
      end
    end
  end

  // Sequencer: scan, write back, deliver.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= '0;
      occupancy <= '0;
      access_clock <= '0;
      res_pend <= 1'b0;
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (res_pend && (!out_valid || m_axis_tready)) begin
        out_valid <= 1'b1;
        out_data <= {6'd0, res.evicted, res.read_value, res.hit};
        res_pend <= 1'b0;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            op <= s_axis_tdata[0];
            key <= s_axis_tdata[32:1];
            wval <= s_axis_tdata[64:33];
            found <= 1'b0; vfound <= 1'b0; ffound <= 1'b0;
            idx <= (AW+1)'(1);
            rd_idx <= '0;
            state <= (MAX_ENTRIES == 1) ? ST_LAST : ST_SCAN;
          end
        end
        ST_SCAN, ST_LAST: begin
          if (rd_ok) begin
            if (!found && rdata.key == key) begin
              found <= 1'b1; hit_idx <= rd_idx; hit_ent <= rdata;
            end
            if (better) begin
              vfound <= 1'b1; vic_idx <= rd_idx; vic_ent <= rdata;
            end
          end else if (!ffound) begin
            ffound <= 1'b1; free_idx <= rd_idx;
          end
          rd_idx <= idx[AW-1:0];
          idx <= idx + 1'b1;
          if (state == ST_LAST) state <= ST_WB;
          else if (idx == (AW+1)'(MAX_ENTRIES-1)) state <= ST_LAST;
        end
        ST_WB: begin
          res.hit <= is_hit && (op == OP_GET || cap_eff != '0);
          res.read_value <= (is_hit && op == OP_GET) ? hit_ent.value : '0;
          res.evicted <= do_ev;
          if (is_hit && (op == OP_GET || cap_eff != '0)) begin
            access_clock <= access_clock + 1'b1;
          end else if (do_ins) begin
            valid[do_ev ? vic_idx : ins_idx] <= 1'b1;
            access_clock <= access_clock + 1'b1;
            if (!do_ev) occupancy <= occupancy + 1'b1;
          end else if (do_ev) begin
            valid[vic_idx] <= 1'b0;
            occupancy <= occupancy - 1'b1;
          end
          res_pend <= 1'b1;
          idx <= '0;
          state <= ST_OUT;
        end
        ST_OUT: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

[rtl/lfu_cache_table_checker.sv]
// Port-level checker for the LFU cache table, bound to the top level.
`include "lfu_cache_table_top_macros.svh"
module lfu_cache_table_sva (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        pready
);
  `LFU_ASSERT_IMP(a_pready, clk, rst, 1'b1, pready)
  `LFU_ASSERT_NEXT(a_busy, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `LFU_ASSERT_IMP(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
                  ##1 (m_axis_tvalid && $stable(m_axis_tdata)))
  `LFU_ASSERT_IMP(a_excl, clk, rst, m_axis_tvalid && m_axis_tdata[0],
                  !m_axis_tdata[33])
endmodule

bind lfu_cache_table_top lfu_cache_table_sva u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .pready(pready));
